[design/dwfb_pkg.sv]
// Shared definitions for the dirty-window frame buffer flush block.
// Opcodes, flush phase codes, panel command bytes and the controller/datapath
// interface types. No dependencies.
`timescale 1ns / 1ps

package dwfb_pkg;

  // Store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field and register widths
  localparam int DIM_W   = 9;
  localparam int POS_W   = 11;
  localparam int COLOR_W = 8;
  localparam int CFG_W   = 9;

  // Opcodes
  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;
  localparam logic [1:0] OP_FILL  = 2'd3;

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd240;

  // Flush phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_CMD_COL   = 4'd1;
  localparam logic [3:0] PH_XL_HI     = 4'd2;
  localparam logic [3:0] PH_XL_LO     = 4'd3;
  localparam logic [3:0] PH_XH_HI     = 4'd4;
  localparam logic [3:0] PH_XH_LO     = 4'd5;
  localparam logic [3:0] PH_CMD_ROW   = 4'd6;
  localparam logic [3:0] PH_YL_HI     = 4'd7;
  localparam logic [3:0] PH_YL_LO     = 4'd8;
  localparam logic [3:0] PH_YH_HI     = 4'd9;
  localparam logic [3:0] PH_YH_LO     = 4'd10;
  localparam logic [3:0] PH_CMD_WRITE = 4'd11;
  localparam logic [3:0] PH_PIXELS    = 4'd12;

  // Panel command bytes
  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // What an input beat means given the current flush phase
  typedef enum logic [2:0] {
    K_NONE   = 3'd0,
    K_DRAW   = 3'd1,
    K_FILL   = 3'd2,
    K_FLUSH  = 3'd3,
    K_HEADER = 3'd4,
    K_PIXEL  = 3'd5
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic mul;       // register row * width
    logic load_end;  // register row * width as the sweep end
    logic wr_draw;   // write the drawn pixel
    logic rd_pixel;  // read the pixel under the scan position
    logic sweep;     // write one store entry of a fill or clear
    logic emit;      // load the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  sweep_last;
    logic  out_free;
  } dp_stat_t;

endpackage

[design/dwfb_ctrl.sv]
// Sequencing state machine for the dirty-window frame buffer flush block.
// Depends on dwfb_pkg for the command and status types.
`timescale 1ns / 1ps

module dwfb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dwfb_pkg::dp_stat_t  stat,
  output dwfb_pkg::ctrl_cmd_t cmd
);
  import dwfb_pkg::*;

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MUL   = 5'b00100,
    S_ADD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;
  kind_t  job, job_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    job_next   = job;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          job_next   = stat.kind;
          case (stat.kind)
            K_DRAW, K_FILL, K_PIXEL: state_next = S_MUL;
            K_HEADER:                state_next = S_EMIT;
            default:                 state_next = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (job == K_FILL) begin
          cmd.load_end = 1'b1;
          state_next   = S_SWEEP;
        end else begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (job == K_PIXEL) begin
          cmd.rd_pixel = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.wr_draw = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      job   <= K_NONE;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

endmodule

[design/dwfb_dp.sv]
// Datapath of the dirty-window frame buffer flush block: size registers,
// dirty window, frame store, address multiplier, flush sequencer and output
// register. Depends on dwfb_pkg.
`timescale 1ns / 1ps

module dwfb_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [dwfb_pkg::CFG_W-1:0]       cfg_data,
  input  logic [1:0]                       opcode,
  input  logic signed [dwfb_pkg::POS_W-1:0] pos_x,
  input  logic signed [dwfb_pkg::POS_W-1:0] pos_y,
  input  logic [dwfb_pkg::COLOR_W-1:0]     red,
  input  logic [dwfb_pkg::COLOR_W-1:0]     green,
  input  logic [dwfb_pkg::COLOR_W-1:0]     blue,
  input  dwfb_pkg::ctrl_cmd_t              cmd,
  output dwfb_pkg::dp_stat_t               stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             is_data,
  output logic                             last_byte
);
  import dwfb_pkg::*;

  // Size clamped to 1..MAX
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

  // RGB888 to one byte {b/4, g/9, r/10} of the 565 components
  function automatic logic [7:0] pack_color(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    logic [4:0]  r5;
    logic [5:0]  g6;
    logic [11:0] gm;
    logic [1:0]  rq;
    r5 = r[7:3];
    g6 = g[7:2];
    gm = 12'(g6) * 12'd57;   // floor(g6 / 9) for g6 < 64
    if (r5 >= 5'd30) rq = 2'd3;
    else if (r5 >= 5'd20) rq = 2'd2;
    else if (r5 >= 5'd10) rq = 2'd1;
    else rq = 2'd0;
    return {b[7:5], gm[11:9], rq};
  endfunction

  // Stored byte back to 565
  function automatic logic [15:0] expand_color(input logic [7:0] s);
    logic [5:0] g9;
    logic [4:0] b10;
    g9  = {s[4:2], 3'b000} + {3'b000, s[4:2]};
    b10 = {s[1:0], 3'b000} + {2'b00, s[1:0], 1'b0};
    return {s[7:5], 2'b00, g9, b10};
  endfunction

  localparam logic [DIM_W-1:0]  W_LIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  H_LIM = DIM_W'(MAX_HEIGHT);
  localparam logic [ADDR_W:0]   CLEAR_END = (ADDR_W+1)'(STORE_DEPTH);

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [DIM_W-1:0] eff_w, eff_h;
  logic [DIM_W-1:0] win_x_low, win_y_low, win_x_high, win_y_high;
  logic [3:0]       flush_phase;
  logic [DIM_W-1:0] scan_column, scan_row;
  logic             low_half_next;
  logic [DIM_W-1:0] row_reg, col_reg;
  logic [7:0]       color;
  logic [2*DIM_W-1:0] mul_full, prod;
  logic [ADDR_W:0]  sweep_cnt, sweep_end, sweep_inc;
  logic [ADDR_W-1:0] addr;
  logic [7:0]       mem [0:STORE_DEPTH-1];
  logic [7:0]       rdata;
  logic [15:0]      pix565;
  logic             draw_ok, win_empty;
  logic [DIM_W-1:0] in_x, in_y;
  logic [7:0]       packed_in;
  logic [7:0]       out_byte_next;
  logic             is_data_next, last_byte_next;

  assign eff_w = clamp_dim(frame_width, W_LIM);
  assign eff_h = clamp_dim(frame_height, H_LIM);

  // Input decode
  assign in_x      = pos_x[DIM_W-1:0];
  assign in_y      = pos_y[DIM_W-1:0];
  assign packed_in = pack_color(red, green, blue);
  assign draw_ok   = !pos_x[POS_W-1] && !pos_y[POS_W-1]
                   && (pos_x < $signed({2'b00, eff_w}))
                   && (pos_y < $signed({2'b00, eff_h}));

  always_comb begin
    stat.kind = K_NONE;
    if (flush_phase == PH_IDLE) begin
      unique case (opcode)
        OP_DRAW:  stat.kind = draw_ok ? K_DRAW : K_NONE;
        OP_FILL:  stat.kind = K_FILL;
        OP_FLUSH: stat.kind = K_FLUSH;
        OP_NEXT:  stat.kind = K_NONE;
        default:  stat.kind = K_NONE;
      endcase
    end else if (opcode == OP_NEXT) begin
      stat.kind = (flush_phase == PH_PIXELS) ? K_PIXEL : K_HEADER;
    end
  end

  assign sweep_inc       = sweep_cnt + 1'b1;
  assign stat.sweep_last = (sweep_inc == sweep_end);
  assign stat.out_free   = !out_valid || out_ready;

  // Store address: row * width + column, wrapping at the store size
  assign mul_full  = {{DIM_W{1'b0}}, row_reg} * {{DIM_W{1'b0}}, eff_w};
  assign addr      = prod[ADDR_W-1:0] + ADDR_W'(col_reg);
  assign pix565    = expand_color(rdata);
  assign win_empty = (win_x_low > win_x_high) || (win_y_low > win_y_high);

  // Frame store
  always_ff @(posedge clk) begin
    if (cmd.sweep) mem[sweep_cnt[ADDR_W-1:0]] <= color;
    else if (cmd.wr_draw) mem[addr] <= color;
    if (cmd.rd_pixel) rdata <= mem[addr];
  end

  // Operand and product registers
  always_ff @(posedge clk) begin
    if (rst) begin
      color <= '0;
    end else if (cmd.accept) begin
      unique case (stat.kind)
        K_DRAW: begin
          row_reg <= in_y;
          col_reg <= in_x;
          color   <= packed_in;
        end
        K_FILL: begin
          row_reg <= eff_h;
          col_reg <= '0;
          color   <= packed_in;
        end
        K_PIXEL: begin
          row_reg <= scan_row;
          col_reg <= scan_column;
        end
        default: ;
      endcase
    end
    if (cmd.mul) prod <= mul_full;
  end

  // Byte for the current flush phase
  always_comb begin
    out_byte_next  = '0;
    is_data_next   = 1'b1;
    last_byte_next = 1'b0;
    unique case (flush_phase)
      PH_CMD_COL: begin
        out_byte_next = CMD_COLUMN_SET;
        is_data_next  = 1'b0;
      end
      PH_XL_HI:   out_byte_next = {7'b0, win_x_low[DIM_W-1]};
      PH_XL_LO:   out_byte_next = win_x_low[7:0];
      PH_XH_HI:   out_byte_next = {7'b0, win_x_high[DIM_W-1]};
      PH_XH_LO:   out_byte_next = win_x_high[7:0];
      PH_CMD_ROW: begin
        out_byte_next = CMD_ROW_SET;
        is_data_next  = 1'b0;
      end
      PH_YL_HI:   out_byte_next = {7'b0, win_y_low[DIM_W-1]};
      PH_YL_LO:   out_byte_next = win_y_low[7:0];
      PH_YH_HI:   out_byte_next = {7'b0, win_y_high[DIM_W-1]};
      PH_YH_LO:   out_byte_next = win_y_high[7:0];
      PH_CMD_WRITE: begin
        out_byte_next  = CMD_MEMORY_WRITE;
        is_data_next   = 1'b0;
        last_byte_next = win_empty;
      end
      PH_PIXELS: begin
        if (!low_half_next) out_byte_next = pix565[15:8];
        else begin
          out_byte_next  = pix565[7:0];
          last_byte_next = (scan_column >= win_x_high) && (scan_row >= win_y_high);
        end
      end
      default: ;
    endcase
  end

  // Control state: size registers, window, sweep, flush sequencer, output
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= CFG_RESET;
      frame_height  <= CFG_RESET;
      win_x_low     <= CFG_RESET;
      win_y_low     <= CFG_RESET;
      win_x_high    <= '0;
      win_y_high    <= '0;
      flush_phase   <= PH_IDLE;
      scan_column   <= '0;
      scan_row      <= '0;
      low_half_next <= 1'b0;
      sweep_cnt     <= '0;
      sweep_end     <= CLEAR_END;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.accept) begin
        case (stat.kind)
          K_DRAW: begin
            if (in_x < win_x_low)  win_x_low  <= in_x;
            if (in_y < win_y_low)  win_y_low  <= in_y;
            if (in_x > win_x_high) win_x_high <= in_x;
            if (in_y > win_y_high) win_y_high <= in_y;
          end
          K_FILL: begin
            win_x_low  <= '0;
            win_y_low  <= '0;
            win_x_high <= eff_w - 1'b1;
            win_y_high <= eff_h - 1'b1;
            sweep_cnt  <= '0;
          end
          K_FLUSH: begin
            if (win_x_high > eff_w - 1'b1) win_x_high <= eff_w - 1'b1;
            if (win_y_high > eff_h - 1'b1) win_y_high <= eff_h - 1'b1;
            flush_phase   <= PH_CMD_COL;
            low_half_next <= 1'b0;
          end
          default: ;
        endcase
      end

      if (cmd.load_end) sweep_end <= mul_full[ADDR_W:0];
      if (cmd.sweep) sweep_cnt <= sweep_inc;

      // Output register
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (cmd.emit) begin
        out_byte  <= out_byte_next;
        is_data   <= is_data_next;
        last_byte <= last_byte_next;

        // Phase advance, scan walk and end of flush
        if (flush_phase == PH_PIXELS) begin
          low_half_next <= !low_half_next;
          if (low_half_next) begin
            if (scan_column < win_x_high) begin
              scan_column <= scan_column + 1'b1;
            end else if (scan_row < win_y_high) begin
              scan_column <= win_x_low;
              scan_row    <= scan_row + 1'b1;
            end else begin
              win_x_low     <= eff_w;
              win_y_low     <= eff_h;
              win_x_high    <= '0;
              win_y_high    <= '0;
              flush_phase   <= PH_IDLE;
              scan_column   <= '0;
              scan_row      <= '0;
            end
          end
        end else if (flush_phase == PH_CMD_WRITE) begin
          low_half_next <= 1'b0;
          if (win_empty) begin
            win_x_low   <= eff_w;
            win_y_low   <= eff_h;
            win_x_high  <= '0;
            win_y_high  <= '0;
            flush_phase <= PH_IDLE;
            scan_column <= '0;
            scan_row    <= '0;
          end else begin
            scan_column <= win_x_low;
            scan_row    <= win_y_low;
            flush_phase <= PH_PIXELS;
          end
        end else begin
          flush_phase <= flush_phase + 1'b1;
        end
      end
    end
  end

endmodule

[design/dirty_window_framebuffer_flush.sv]
// Top level of the dirty-window frame buffer flush block.
// Instantiates dwfb_ctrl and dwfb_dp; depends on dwfb_pkg.
`timescale 1ns / 1ps

// An 8-bit-per-pixel frame store (256 x 256 entries, one write and one read
// port) with a dirty bounding window and a byte stream for an RGB565 panel.
// After reset the store is cleared by a pass over all entries, one entry a
// cycle, during which in_ready stays low; configuration writes are taken at
// any time. Items are handled one at a time: an ignored item, a flush start
// or a dropped draw ends on acceptance, a draw multiplies row by width, then
// adds the column and writes, a header byte loads the output register, a
// pixel byte multiplies, adds and reads, then loads the output register, and
// a fill writes w*h entries, one a cycle, through the single write port. A
// result waiting in the output register stalls only the next item that yields a byte.
module dirty_window_framebuffer_flush (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [dwfb_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic signed [dwfb_pkg::POS_W-1:0] pos_x,
  input  logic signed [dwfb_pkg::POS_W-1:0] pos_y,
  input  logic [dwfb_pkg::COLOR_W-1:0]      red,
  input  logic [dwfb_pkg::COLOR_W-1:0]      green,
  input  logic [dwfb_pkg::COLOR_W-1:0]      blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              is_data,
  output logic                              last_byte
);
  import dwfb_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  dwfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, window and byte stream
  dwfb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opcode    (opcode),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last_byte (last_byte)
  );

endmodule

[dv/dirty_window_framebuffer_flush_test.sv]
// Self-checking testbench for dirty_window_framebuffer_flush: drives draw, fill,
// flush and next-byte beats, predicts the panel byte stream and checks each beat.
// Depends on design/dwfb_pkg.sv and design/dirty_window_framebuffer_flush.sv.
`timescale 1ns / 1ps

module dirty_window_framebuffer_flush_test;
  import dwfb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  // One byte on the panel link
  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
  } link_beat_t;

  // Frame store and flush sequencer shadow, plus the queue of bytes due
  class frame_flush_scoreboard;
    logic [7:0]       frame [STORE_DEPTH];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int               x_lo, y_lo, x_hi, y_hi, col, row;
    logic [3:0]       phase;
    bit               low_half;
    link_beat_t       bytes_due[$];
    int               errors;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      width_reg  = CFG_RESET;
      height_reg = CFG_RESET;
      errors     = 0;
      end_flush();
    endfunction

    // Register values of 0 act as 1, values above the store size saturate
    function int eff_dim(logic [CFG_W-1:0] v, int lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
    endfunction

    function logic [7:0] pack_332(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return {3'(b[7:3] / 4), 3'(g[7:2] / 9), 2'(r[7:3] / 10)};
    endfunction

    function void end_flush();
      x_lo     = eff_dim(width_reg, MAX_WIDTH);
      y_lo     = eff_dim(height_reg, MAX_HEIGHT);
      x_hi     = 0;
      y_hi     = 0;
      phase    = PH_IDLE;
      col      = 0;
      row      = 0;
      low_half = 1'b0;
    endfunction

    function void due(logic [7:0] data, logic is_data, logic last);
      bytes_due.push_back('{data: data, is_data: is_data, last: last});
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] v);
      if (idx == REG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
    endfunction

    function bit flushing();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction

    // Apply one accepted input beat; returns an upper bound on how long the block stays busy
    function int take_item(logic [1:0] op, logic signed [POS_W-1:0] px,
                           logic signed [POS_W-1:0] py, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b);
      int         w, h, xi, yi, idx;
      logic [7:0] s;
      logic [15:0] rgb;
      w  = eff_dim(width_reg, MAX_WIDTH);
      h  = eff_dim(height_reg, MAX_HEIGHT);
      xi = px;
      yi = py;
      if (phase == PH_IDLE) begin
        case (op)
          OP_DRAW: begin
            if (xi >= 0 && yi >= 0 && xi < w && yi < h) begin
              if (xi < x_lo) x_lo = xi;
              if (yi < y_lo) y_lo = yi;
              if (xi > x_hi) x_hi = xi;
              if (yi > y_hi) y_hi = yi;
              frame[(yi * w + xi) % STORE_DEPTH] = pack_332(r, g, b);
            end
          end
          OP_FILL: begin
            for (idx = 0; idx < w * h; idx++) frame[idx] = pack_332(r, g, b);
            x_lo = 0;
            y_lo = 0;
            x_hi = w - 1;
            y_hi = h - 1;
            return w * h + 2;
          end
          OP_FLUSH: begin
            // high corners clipped to the frame as it stands now
            if (x_hi > w - 1) x_hi = w - 1;
            if (y_hi > h - 1) y_hi = h - 1;
            phase    = PH_CMD_COL;
            low_half = 1'b0;
          end
          default: ;
        endcase
        return 4;
      end

      // draw, fill and flush are dropped while a flush runs
      if (op != OP_NEXT) return 4;
      case (phase)
        PH_CMD_COL: begin due(CMD_COLUMN_SET, 1'b0, 1'b0); phase = PH_XL_HI; end
        PH_XL_HI:   begin due(8'(x_lo >> 8), 1'b1, 1'b0); phase = PH_XL_LO; end
        PH_XL_LO:   begin due(8'(x_lo), 1'b1, 1'b0); phase = PH_XH_HI; end
        PH_XH_HI:   begin due(8'(x_hi >> 8), 1'b1, 1'b0); phase = PH_XH_LO; end
        PH_XH_LO:   begin due(8'(x_hi), 1'b1, 1'b0); phase = PH_CMD_ROW; end
        PH_CMD_ROW: begin due(CMD_ROW_SET, 1'b0, 1'b0); phase = PH_YL_HI; end
        PH_YL_HI:   begin due(8'(y_lo >> 8), 1'b1, 1'b0); phase = PH_YL_LO; end
        PH_YL_LO:   begin due(8'(y_lo), 1'b1, 1'b0); phase = PH_YH_HI; end
        PH_YH_HI:   begin due(8'(y_hi >> 8), 1'b1, 1'b0); phase = PH_YH_LO; end
        PH_YH_LO:   begin due(8'(y_hi), 1'b1, 1'b0); phase = PH_CMD_WRITE; end
        PH_CMD_WRITE: begin
          // empty window: memory-write closes the flush with no pixels
          if (x_lo > x_hi || y_lo > y_hi) begin
            end_flush();
            due(CMD_MEMORY_WRITE, 1'b0, 1'b1);
          end else begin
            col      = x_lo;
            row      = y_lo;
            low_half = 1'b0;
            phase    = PH_PIXELS;
            due(CMD_MEMORY_WRITE, 1'b0, 1'b0);
          end
        end
        default: begin
          s   = frame[(row * w + col) % STORE_DEPTH];
          rgb = {5'(s[7:5] * 4), 6'(s[4:2] * 9), 5'(s[1:0] * 10)};
          if (!low_half) begin
            low_half = 1'b1;
            due(rgb[15:8], 1'b1, 1'b0);
          end else begin
            low_half = 1'b0;
            if (col < x_hi) begin
              col++;
            end else if (row < y_hi) begin
              col = x_lo;
              row++;
            end else begin
              end_flush();
              due(rgb[7:0], 1'b1, 1'b1);
              return 4;
            end
            due(rgb[7:0], 1'b1, 1'b0);
          end
        end
      endcase
      return 4;
    endfunction

    // Compare one output beat against the oldest byte due
    function void check_link_beat(logic [7:0] data, logic is_data, logic last);
      link_beat_t want;
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got byte %h is_data %b last %b",
                 $time, data, is_data, last);
        errors++;
        return;
      end
      want = bytes_due.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %h, got %h", $time, want.data, data);
        errors++;
      end
      if (is_data !== want.is_data) begin
        $display("%0t: is_data expected %b, got %b", $time, want.is_data, is_data);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_byte expected %b, got %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic                    cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              opcode;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [COLOR_W-1:0]      red;
  logic [COLOR_W-1:0]      green;
  logic [COLOR_W-1:0]      blue;
  logic                    out_valid;
  logic                    out_ready;
  logic [7:0]              out_byte;
  logic                    is_data;
  logic                    last_byte;

  frame_flush_scoreboard sb;
  bit                    no_idle;
  int                    busy_tail;
  int                    cycles;

  dirty_window_framebuffer_flush i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last_byte (last_byte)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 29);
  end

  // Sample beats and register writes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_link_beat(out_byte, is_data, last_byte);
      if (in_valid && in_ready)
        busy_tail = sb.take_item(opcode, pos_x, pos_y, red, green, blue);
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("dirty_window_framebuffer_flush regression: fail");
      $finish;
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic int any_pos();
    return int'($urandom_range(2047)) - 1024;
  endfunction

  // Present one input beat; called and returns at a falling edge
  task automatic send(logic [1:0] op, int x, int y, logic [7:0] r, logic [7:0] g,
                      logic [7:0] b);
    if (!no_idle && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    opcode   <= op;
    pos_x    <= x[POS_W-1:0];
    pos_y    <= y[POS_W-1:0];
    red      <= r;
    green    <= g;
    blue     <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Wait for every byte due, then for the last beat's own work
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (busy_tail + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_size(int w, int h);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic finish_flush();
    while (sb.flushing()) send(OP_NEXT, any_pos(), any_pos(), any_byte(), any_byte(), any_byte());
  endtask

  task automatic flush_all();
    finish_flush();
    send(OP_FLUSH, 0, 0, any_byte(), any_byte(), any_byte());
    finish_flush();
  endtask

  // Random traffic in one frame size; draws cluster in a small box so flushes stay short
  task automatic run_phase(int w, int h, int n);
    int         ew, eh, bw, bh, ax, ay, x, y, pick;
    logic [1:0] op;
    set_size(w, h);
    ew = sb.eff_dim(w[CFG_W-1:0], MAX_WIDTH);
    eh = sb.eff_dim(h[CFG_W-1:0], MAX_HEIGHT);
    bw = (ew < 6) ? ew : 6;
    bh = (eh < 6) ? eh : 6;
    ax = $urandom_range(ew - bw);
    ay = $urandom_range(eh - bh);
    repeat (n) begin
      if (sb.flushing()) begin
        op = ($urandom_range(99) < 88) ? OP_NEXT : 2'($urandom_range(3));
        x  = any_pos();
        y  = any_pos();
      end else begin
        pick = $urandom_range(99);
        op   = OP_DRAW;
        x    = ax + $urandom_range(bw - 1);
        y    = ay + $urandom_range(bh - 1);
        if (pick >= 96 && ew * eh <= 96) begin
          op = OP_FILL;
        end else if (pick >= 92) begin
          op = OP_NEXT;
        end else if (pick >= 80) begin
          op = OP_FLUSH;
        end else if (pick >= 66) begin
          // stray draw: any bits, pushed off the frame if it lands inside
          x = any_pos();
          y = any_pos();
          if (x >= 0 && x < ew && y >= 0 && y < eh) y = eh + $urandom_range(1023 - eh);
        end
      end
      send(op, x, y, any_byte(), any_byte(), any_byte());
    end
    flush_all();
  endtask

  initial begin
    sb        = new();
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    opcode    = OP_DRAW;
    pos_x     = '0;
    pos_y     = '0;
    red       = '0;
    green     = '0;
    blue      = '0;
    out_ready = 1'b0;
    no_idle   = 1'b0;
    busy_tail = 0;
    cycles    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: next byte while idle, then an empty-window flush at reset size
    send(OP_NEXT, 0, 0, 8'h00, 8'h00, 8'h00);
    flush_all();
    send(OP_NEXT, 0, 0, 8'hFF, 8'hFF, 8'hFF);

    // Off-frame draws are dropped; two pixels make a 2x2 window
    send(OP_DRAW, -1, 0, 8'hFF, 8'hFF, 8'hFF);
    send(OP_DRAW, 0, -1024, 8'hFF, 8'hFF, 8'hFF);
    send(OP_DRAW, 240, 5, 8'hFF, 8'hFF, 8'hFF);
    send(OP_DRAW, 1023, 1023, 8'hFF, 8'hFF, 8'hFF);
    send(OP_DRAW, 0, 0, 8'hFF, 8'hFF, 8'hFF);
    send(OP_DRAW, 1, 1, 8'h08, 8'h5A, 8'hC8);
    send(OP_FLUSH, 0, 0, 8'h00, 8'h00, 8'h00);
    // everything but next byte is ignored mid-flush
    send(OP_DRAW, 5, 5, 8'hFF, 8'h00, 8'hFF);
    send(OP_FILL, 0, 0, 8'h00, 8'hFF, 8'h00);
    send(OP_FLUSH, 0, 0, 8'h00, 8'h00, 8'h00);
    finish_flush();

    // Full-frame fill, then a smaller frame clips the window at flush start
    send(OP_FILL, 0, 0, 8'hC8, 8'h64, 8'h32);
    set_size(2, 2);
    flush_all();

    // Zero size acts as one pixel
    set_size(0, 0);
    send(OP_DRAW, 0, 0, 8'h00, 8'h00, 8'h00);
    send(OP_DRAW, 1, 0, 8'hFF, 8'hFF, 8'hFF);
    flush_all();

    // Oversize width saturates; window reaches the last column
    set_size(511, 1);
    send(OP_DRAW, 250, 0, 8'h80, 8'h40, 8'h20);
    send(OP_DRAW, 255, 0, 8'hFF, 8'hFF, 8'hFF);
    flush_all();

    // Width change in the middle of a pixel scan
    set_size(1, 256);
    send(OP_DRAW, 0, 254, 8'h33, 8'hCC, 8'h77);
    send(OP_DRAW, 0, 255, 8'hF0, 8'h0F, 8'hA5);
    send(OP_FLUSH, 0, 0, 8'h00, 8'h00, 8'h00);
    repeat (13) send(OP_NEXT, 0, 0, 8'h00, 8'h00, 8'h00);
    set_size(2, 256);
    finish_flush();

    // Largest fill covers the whole store
    set_size(256, 256);
    send(OP_FILL, 0, 0, any_byte(), any_byte(), any_byte());
    set_size(3, 2);
    send(OP_DRAW, 2, 1, 8'h00, 8'h00, 8'h00);
    flush_all();

    // Random phases over several frame sizes, one of them with no idling
    run_phase(8, 8, 40);
    run_phase(0, 0, 40);
    run_phase(511, 3, 40);
    run_phase(256, 256, 40);
    no_idle = 1'b1;
    run_phase(17, 5, 40);
    no_idle = 1'b0;
    run_phase(3, 300, 40);
    run_phase(256, 1, 40);
    run_phase(1, 256, 40);
    run_phase(100, 200, 40);
    run_phase(7, 9, 40);
    run_phase(240, 240, 40);

    settle();
    if (sb.errors == 0) begin
      $display("dirty_window_framebuffer_flush regression: pass");
    end else begin
      $display("dirty_window_framebuffer_flush regression: fail");
    end
    $finish;
  end

endmodule
